// ===== src/mbm_pkg.sv =====
// ----------------------------------------------------------------------------
// mbm_pkg - shared types and constants of the Modbus RTU motor link master
// Configuration, controller/datapath command and status, result and CRC step.
// ----------------------------------------------------------------------------
`default_nettype none
package mbm_pkg;

  localparam logic [1:0] KIND_UPDATE = 2'd0;
  localparam logic [1:0] KIND_RXBYTE = 2'd1;
  localparam logic [1:0] KIND_PROBE  = 2'd2;

  localparam logic [2:0] CLS_NONE    = 3'd0;
  localparam logic [2:0] CLS_READ_OK = 3'd1;
  localparam logic [2:0] CLS_WR_ACK  = 3'd2;
  localparam logic [2:0] CLS_EXCEPT  = 3'd3;
  localparam logic [2:0] CLS_CRC_ERR = 3'd4;
  localparam logic [2:0] CLS_TIMEOUT = 3'd5;
  localparam logic [2:0] CLS_UNEXPEC = 3'd6;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_WR_RPM = 3'd1;
  localparam logic [2:0] PH_WR_CTL = 3'd2;
  localparam logic [2:0] PH_RD_SPD = 3'd3;
  localparam logic [2:0] PH_RD_STA = 3'd4;

  localparam logic [15:0] REG_CTRL  = 16'h8000;
  localparam logic [15:0] REG_RPM   = 16'h8005;
  localparam logic [15:0] REG_SPEED = 16'h8018;
  localparam logic [15:0] REG_STAT  = 16'h801B;

  localparam logic [7:0] FN_READ  = 8'h03;
  localparam logic [7:0] FN_WRITE = 8'h06;
  localparam logic [7:0] FN_EXC   = 8'h80;

  localparam logic [7:0] CTRL_FWD  = 8'h09;
  localparam logic [7:0] CTRL_REV  = 8'h0B;
  localparam logic [7:0] CTRL_STOP = 8'h0C;
  localparam logic [7:0] CTRL_NONE = 8'hFF;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [31:0] LINK_WINDOW_MS = 32'd1500;
  localparam logic [3:0]  LEN_READ  = 4'd7;
  localparam logic [3:0]  LEN_WRITE = 4'd8;
  localparam logic [3:0]  FRAME_LAST = 4'd7;
  localparam logic [3:0]  CAP_BYTES = 4'd8;
  localparam logic [4:0]  DIV_STEPS = 5'd21;

  localparam logic [1:0] CFG_SLAVE   = 2'd0;
  localparam logic [1:0] CFG_POLES   = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;
  localparam logic [1:0] CFG_GAP     = 2'd3;

  typedef struct packed {
    logic [7:0]  slave_address;
    logic [7:0]  pole_pairs;
    logic [15:0] reply_timeout_ms;
    logic [15:0] frame_gap_ms;
  } cfg_t;

  typedef struct packed {
    logic latch;
    logic rx_store;
    logic probe_set;
    logic read_init;
    logic rd_take;
    logic judge_apply;
    logic frame_sel;
    logic link_upd;
    logic emit_stat;
    logic emit_tx;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       awaiting;
    logic       gap_ok;
    logic       rd_more;
    logic       need_div;
    logic       div_busy;
    logic       last_byte;
  } sts_t;

  typedef struct packed {
    logic        is_tx;
    logic [7:0]  tx_byte;
    logic        last;
    logic        motor_on;
    logic [2:0]  reply_class;
    logic [20:0] measured_rpm;
    logic [7:0]  fault_code;
    logic [7:0]  exception_code;
    logic        link_up;
    logic        awaiting_reply;
  } res_t;

  // one byte of CRC-16/MODBUS, reflected, bit by bit
  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== src/mbm_ram.sv =====
// ----------------------------------------------------------------------------
// mbm_ram - generic single-port-write RAM with registered read
// One write port, one read port, read data valid the cycle after the address.
// ----------------------------------------------------------------------------
`default_nettype none
module mbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/mbm_ctrl.sv =====
// ----------------------------------------------------------------------------
// mbm_ctrl - sequencer of the Modbus RTU motor link master
// Walks each transaction through dispatch, byte store, probe set, reply judging, link update or frame send.
// ----------------------------------------------------------------------------
`default_nettype none
module mbm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic          out_free,
  input  wire mbm_pkg::sts_t sts,
  output mbm_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_RD_ADDR, S_RD_DATA, S_EVAL, S_DIV, S_LINK, S_STAT, S_TX
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.kind == mbm_pkg::KIND_RXBYTE) begin
          cmd.rx_store = 1'b1;
          state_next   = S_STAT;
        end else if (sts.kind == mbm_pkg::KIND_PROBE) begin
          cmd.probe_set = 1'b1;
          state_next    = S_STAT;
        end else if (sts.awaiting) begin
          cmd.read_init = 1'b1;
          state_next    = S_RD_ADDR;
        end else if (sts.gap_ok) begin
          cmd.frame_sel = 1'b1;
          state_next    = S_TX;
        end else begin
          state_next = S_LINK;
        end
      end
      S_RD_ADDR: begin
        state_next = sts.rd_more ? S_RD_DATA : S_EVAL;
      end
      S_RD_DATA: begin
        cmd.rd_take = 1'b1;
        state_next  = S_RD_ADDR;
      end
      S_EVAL: begin
        cmd.judge_apply = 1'b1;
        state_next      = sts.need_div ? S_DIV : S_LINK;
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          state_next = S_LINK;
        end
      end
      S_LINK: begin
        cmd.link_upd = 1'b1;
        state_next   = S_STAT;
      end
      S_STAT: begin
        if (out_free) begin
          cmd.emit_stat = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_TX: begin
        if (out_free) begin
          cmd.emit_tx = 1'b1;
          if (sts.last_byte) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/mbm_dp.sv =====
// ----------------------------------------------------------------------------
// mbm_dp - datapath of the Modbus RTU motor link master
// Reply store, CRC unit, reply judging, frame builder and speed divider.
// ----------------------------------------------------------------------------
`default_nettype none
module mbm_dp #(
  parameter int REPLY_BYTES = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire mbm_pkg::cfg_t cfg,
  input  wire logic [1:0]    kind_in,
  input  wire logic [7:0]    rx_in,
  input  wire logic [31:0]   now_in,
  input  wire logic [1:0]    dir_in,
  input  wire logic [15:0]   rpm_in,
  input  wire mbm_pkg::cmd_t cmd,
  output mbm_pkg::sts_t      sts,
  output mbm_pkg::res_t      res
);

  localparam int AW = $clog2(REPLY_BYTES);
  localparam int CW = $clog2(REPLY_BYTES + 1);

  // latched transaction
  logic [1:0]  kind_l;
  logic [7:0]  rx_l;
  logic [31:0] now_l;
  logic [1:0]  dir_l;
  logic [15:0] rpm_l;

  // link state
  logic [CW-1:0] reply_count;
  logic [3:0]    expected_count;
  logic [2:0]    phase;
  logic [31:0]   request_start_time, last_frame_time, last_valid_time;
  logic [15:0]   sent_speed;
  logic          sent_speed_valid;
  logic [7:0]    sent_control;
  logic          probe_pending, link_established, link_flag;
  logic [1:0]    poll_counter;
  logic [20:0]   speed_reading;
  logic [7:0]    fault_reading, exception_reading;
  logic [2:0]    cls_reg;

  // byte walker, CRC and captured reply bytes
  logic [3:0]  idx;
  logic [15:0] crc, crc3, crcn;
  logic [7:0]  b0, b1, b2, b3, b4, t_lo, t_hi;
  logic [7:0]  rdata;

  // frame fields
  logic [7:0]  f_fn, f_hi, f_lo;
  logic [15:0] f_reg;

  // speed divider
  logic        div_busy;
  logic [4:0]  div_cnt;
  logic [20:0] div_q;
  logic [7:0]  div_r, div_d;

  mbm_ram #(.WIDTH(8), .DEPTH(REPLY_BYTES)) u_store (
    .clk   (clk),
    .we    (cmd.rx_store && expected_count != 4'd0 && reply_count < CW'(REPLY_BYTES)),
    .waddr (reply_count[AW-1:0]),
    .wdata (rx_l),
    .raddr (AW'(idx[2:0])),
    .rdata (rdata)
  );

  logic       run;
  logic [7:0] want;
  assign run  = (rpm_l != 16'd0) && (dir_l == 2'd1 || dir_l == 2'd3);
  assign want = run ? ((dir_l == 2'd1) ? mbm_pkg::CTRL_FWD : mbm_pkg::CTRL_REV)
                    : mbm_pkg::CTRL_STOP;

  logic link_eval;
  assign link_eval = (last_valid_time != 32'd0) &&
                     ((now_l - last_valid_time) < mbm_pkg::LINK_WINDOW_MS);

  // reply judging
  logic       exc_hit, exc_ok, short_rx, tmo, len8, crc_ok, rd_ok, wr_ok;
  logic [2:0] cls_eval;
  assign exc_hit  = (reply_count >= CW'(5)) && (b0 == cfg.slave_address) && b1[7];
  assign exc_ok   = ({b4, b3} == crc3);
  assign short_rx = reply_count < CW'(expected_count);
  assign tmo      = (now_l - request_start_time) > {16'd0, cfg.reply_timeout_ms};
  assign len8     = (expected_count == mbm_pkg::LEN_WRITE);
  assign crc_ok   = ({t_hi, t_lo} == crcn);
  assign rd_ok    = crc_ok && b0 == cfg.slave_address && b1 == mbm_pkg::FN_READ &&
                    !len8 && b2 == 8'd2;
  assign wr_ok    = crc_ok && len8 && b0 == cfg.slave_address && b1 == mbm_pkg::FN_WRITE;

  always_comb begin
    if (exc_hit) begin
      cls_eval = exc_ok ? mbm_pkg::CLS_EXCEPT : mbm_pkg::CLS_CRC_ERR;
    end else if (short_rx) begin
      cls_eval = tmo ? mbm_pkg::CLS_TIMEOUT : mbm_pkg::CLS_NONE;
    end else if (rd_ok) begin
      cls_eval = mbm_pkg::CLS_READ_OK;
    end else if (wr_ok) begin
      cls_eval = mbm_pkg::CLS_WR_ACK;
    end else begin
      cls_eval = crc_ok ? mbm_pkg::CLS_UNEXPEC : mbm_pkg::CLS_CRC_ERR;
    end
  end

  logic judge_done, drop_wr, mark;
  assign judge_done = !(short_rx && !exc_hit && !tmo);
  assign drop_wr    = !exc_hit && ((short_rx && tmo) ||
                      (!short_rx && !rd_ok && !wr_ok));
  assign mark       = (exc_hit && exc_ok) || (!exc_hit && !short_rx && (rd_ok || wr_ok));

  // next frame choice
  logic [1:0] poll_next;
  assign poll_next = poll_counter + 2'd1;

  logic [7:0] frame_byte;
  always_comb begin
    case (idx[2:0])
      3'd0:    frame_byte = cfg.slave_address;
      3'd1:    frame_byte = f_fn;
      3'd2:    frame_byte = f_reg[15:8];
      3'd3:    frame_byte = f_reg[7:0];
      3'd4:    frame_byte = f_hi;
      3'd5:    frame_byte = f_lo;
      3'd6:    frame_byte = crc[7:0];
      default: frame_byte = crc[15:8];
    endcase
  end

  logic [15:0] crc_rd, crc_tx;
  assign crc_rd = mbm_pkg::crc_byte(crc, rdata);
  assign crc_tx = mbm_pkg::crc_byte(crc, frame_byte);

  logic [20:0] raw20;
  assign raw20 = ({5'd0, b3, b4} << 4) + ({5'd0, b3, b4} << 2);

  logic [8:0] div_t;
  assign div_t = {div_r, div_q[20]};

  // control and link state
  always_ff @(posedge clk) begin
    if (rst) begin
      reply_count <= '0;  expected_count <= '0;  phase <= mbm_pkg::PH_IDLE;
      request_start_time <= '0;  last_frame_time <= '0;  last_valid_time <= '0;
      sent_speed <= '0;  sent_speed_valid <= 1'b0;  sent_control <= mbm_pkg::CTRL_NONE;
      probe_pending <= 1'b0;  link_established <= 1'b0;  link_flag <= 1'b0;
      poll_counter <= '0;  speed_reading <= '0;  fault_reading <= '0;
      exception_reading <= '0;  cls_reg <= mbm_pkg::CLS_NONE;
      idx <= '0;  div_busy <= 1'b0;  div_cnt <= '0;
    end else begin
      if (cmd.latch) begin
        cls_reg <= mbm_pkg::CLS_NONE;
      end
      if (cmd.rx_store && expected_count != 4'd0 && reply_count < CW'(REPLY_BYTES)) begin
        reply_count <= reply_count + CW'(1);
      end
      if (cmd.probe_set) begin
        probe_pending <= 1'b1;
      end
      if (cmd.read_init) begin
        idx <= '0;
      end
      if (cmd.rd_take) begin
        idx <= idx + 4'd1;
      end
      if (cmd.judge_apply) begin
        cls_reg <= cls_eval;
        if (exc_hit) begin
          exception_reading <= b2;
        end else if (!short_rx) begin
          exception_reading <= 8'd0;
        end
        if (!exc_hit && !short_rx && rd_ok && phase == mbm_pkg::PH_RD_STA) begin
          fault_reading <= b3;
        end
        if (mark) begin
          link_established <= 1'b1;
          last_valid_time  <= now_l;
        end
        if (drop_wr && phase == mbm_pkg::PH_WR_RPM) begin
          sent_speed_valid <= 1'b0;
        end
        if (drop_wr && phase == mbm_pkg::PH_WR_CTL) begin
          sent_control <= mbm_pkg::CTRL_NONE;
        end
        if (judge_done) begin
          expected_count <= '0;
          phase          <= mbm_pkg::PH_IDLE;
        end
        if (sts.need_div) begin
          div_busy <= 1'b1;
          div_cnt  <= '0;
        end
      end
      if (div_busy) begin
        div_cnt <= div_cnt + 5'd1;
        if (div_cnt == mbm_pkg::DIV_STEPS - 5'd1) begin
          div_busy      <= 1'b0;
          speed_reading <= {div_q[19:0], (div_t >= {1'b0, div_d})};
        end
      end
      if (cmd.frame_sel) begin
        if (probe_pending || !link_established) begin
          probe_pending <= 1'b0;
          phase         <= mbm_pkg::PH_RD_STA;
        end else if (!sent_speed_valid || sent_speed != rpm_l) begin
          phase            <= mbm_pkg::PH_WR_RPM;
          sent_speed       <= rpm_l;
          sent_speed_valid <= 1'b1;
        end else if (sent_control != want) begin
          phase        <= mbm_pkg::PH_WR_CTL;
          sent_control <= want;
        end else begin
          poll_counter <= poll_next;
          phase <= (poll_next == 2'd0) ? mbm_pkg::PH_RD_STA : mbm_pkg::PH_RD_SPD;
        end
        reply_count <= '0;
        expected_count <= (!(probe_pending || !link_established) &&
                           (!sent_speed_valid || sent_speed != rpm_l || sent_control != want))
                          ? mbm_pkg::LEN_WRITE : mbm_pkg::LEN_READ;
        request_start_time <= now_l;
        last_frame_time    <= now_l;
        link_flag          <= link_eval;
        idx                <= '0;
      end
      if (cmd.link_upd) begin
        link_flag <= link_eval;
      end
      if (cmd.emit_tx) begin
        idx <= idx + 4'd1;
      end
    end
  end

  // payload: latched inputs, captures, CRC, frame fields, divider data
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_l <= kind_in;  rx_l <= rx_in;  now_l <= now_in;
      dir_l  <= dir_in;   rpm_l <= rpm_in;
    end
    if (cmd.read_init) begin
      crc <= mbm_pkg::CRC_INIT;
    end
    if (cmd.rd_take) begin
      crc <= crc_rd;
      if (idx == 4'd2) crc3 <= crc_rd;
      if (idx == expected_count - 4'd3) crcn <= crc_rd;
      if (idx == 4'd0) b0 <= rdata;
      if (idx == 4'd1) b1 <= rdata;
      if (idx == 4'd2) b2 <= rdata;
      if (idx == 4'd3) b3 <= rdata;
      if (idx == 4'd4) b4 <= rdata;
      if (idx == expected_count - 4'd2) t_lo <= rdata;
      if (idx == expected_count - 4'd1) t_hi <= rdata;
    end
    if (cmd.judge_apply && sts.need_div) begin
      div_q <= raw20;
      div_r <= 8'd0;
      div_d <= (cfg.pole_pairs == 8'd0) ? 8'd1 : cfg.pole_pairs;
    end else if (div_busy) begin
      div_q <= {div_q[19:0], (div_t >= {1'b0, div_d})};
      div_r <= (div_t >= {1'b0, div_d}) ? 8'(div_t - {1'b0, div_d}) : div_t[7:0];
    end
    if (cmd.frame_sel) begin
      crc <= mbm_pkg::CRC_INIT;
      if (probe_pending || !link_established) begin
        f_fn <= mbm_pkg::FN_READ;  f_reg <= mbm_pkg::REG_STAT;
        f_hi <= 8'd0;  f_lo <= 8'd1;
      end else if (!sent_speed_valid || sent_speed != rpm_l) begin
        f_fn <= mbm_pkg::FN_WRITE;  f_reg <= mbm_pkg::REG_RPM;
        f_hi <= rpm_l[7:0];  f_lo <= rpm_l[15:8];
      end else if (sent_control != want) begin
        f_fn <= mbm_pkg::FN_WRITE;  f_reg <= mbm_pkg::REG_CTRL;
        f_hi <= want;  f_lo <= cfg.pole_pairs;
      end else begin
        f_fn  <= mbm_pkg::FN_READ;
        f_reg <= (poll_next == 2'd0) ? mbm_pkg::REG_STAT : mbm_pkg::REG_SPEED;
        f_hi  <= 8'd0;  f_lo <= 8'd1;
      end
    end
    if (cmd.emit_tx && idx < 4'd6) begin
      crc <= crc_tx;
    end
  end

  always_comb begin
    sts.kind      = kind_l;
    sts.awaiting  = (expected_count != 4'd0);
    sts.gap_ok    = (now_l - last_frame_time) >= {16'd0, cfg.frame_gap_ms};
    sts.rd_more   = (idx < mbm_pkg::CAP_BYTES) && (CW'(idx) < reply_count);
    sts.need_div  = exc_hit ? 1'b0 : (!short_rx && rd_ok && phase == mbm_pkg::PH_RD_SPD);
    sts.div_busy  = div_busy;
    sts.last_byte = (idx == mbm_pkg::FRAME_LAST);
  end

  always_comb begin
    res.is_tx          = cmd.emit_tx;
    res.tx_byte        = cmd.emit_tx ? frame_byte : 8'd0;
    res.last           = cmd.emit_tx ? (idx == mbm_pkg::FRAME_LAST) : 1'b1;
    res.motor_on       = run;
    res.reply_class    = cmd.emit_tx ? mbm_pkg::CLS_NONE : cls_reg;
    res.measured_rpm   = speed_reading;
    res.fault_code     = fault_reading;
    res.exception_code = exception_reading;
    res.link_up        = link_flag;
    res.awaiting_reply = (expected_count != 4'd0);
  end

  a_len_legal: assert property (@(posedge clk) disable iff (rst)
    expected_count == 4'd0 || expected_count == mbm_pkg::LEN_READ ||
    expected_count == mbm_pkg::LEN_WRITE)
    else $error("expected reply length out of range");

  a_phase_tracks_wait: assert property (@(posedge clk) disable iff (rst)
    (phase != mbm_pkg::PH_IDLE) == (expected_count != 4'd0))
    else $error("transaction phase and awaited reply disagree");

  a_store_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.rx_store && reply_count == CW'(REPLY_BYTES) |=> reply_count == CW'(REPLY_BYTES))
    else $error("reply store overfilled");

endmodule
`default_nettype wire

// ===== src/modbus_rtu_motor_link_master.sv =====
// ----------------------------------------------------------------------------
// modbus_rtu_motor_link_master - Modbus RTU master for one motor controller
// Buffers reply bytes, judges replies and sends CRC-16 request frames.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) takes one transaction a time: an update
// pass, a received bus byte or a probe request. The output channel
// (out_valid/out_stall) returns one status result, or eight frame bytes when
// an update sends a request; last marks the final result of a transaction.
// An update that judges a reply reads the reply store a byte at a time (up to
// eight bytes), then evaluates the reply and, for a speed read, waits for the
// bit-serial divider. The next transaction is accepted while the final result
// still sits in the output register. A stalled receiver holds the output
// register and the sequencer waits before each further result. Reset clears
// all link state and restores the configuration defaults; the reply store
// needs no clearing. Configuration is written over the APB port at byte
// addresses 0, 4, 8, 12.
// ----------------------------------------------------------------------------
`default_nettype none
module modbus_rtu_motor_link_master #(
  parameter int REPLY_BYTES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [31:0] now_ms,
  input  wire logic [1:0]  motor_dir,
  input  wire logic [15:0] rpm_setpoint,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             is_tx,
  output logic [7:0]       tx_byte,
  output logic             last,
  output logic             motor_on,
  output logic [2:0]       reply_class,
  output logic [20:0]      measured_rpm,
  output logic [7:0]       fault_code,
  output logic [7:0]       exception_code,
  output logic             link_up,
  output logic             awaiting_reply
);

  mbm_pkg::cfg_t cfg;
  mbm_pkg::cmd_t cmd;
  mbm_pkg::sts_t sts;
  mbm_pkg::res_t res;
  logic          out_free;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slave_address    <= 8'd1;
      cfg.pole_pairs       <= 8'd2;
      cfg.reply_timeout_ms <= 16'd200;
      cfg.frame_gap_ms     <= 16'd250;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        mbm_pkg::CFG_SLAVE:   cfg.slave_address    <= pwdata[7:0];
        mbm_pkg::CFG_POLES:   cfg.pole_pairs       <= pwdata[7:0];
        mbm_pkg::CFG_TIMEOUT: cfg.reply_timeout_ms <= pwdata[15:0];
        mbm_pkg::CFG_GAP:     cfg.frame_gap_ms     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      mbm_pkg::CFG_SLAVE:   prdata = {24'd0, cfg.slave_address};
      mbm_pkg::CFG_POLES:   prdata = {24'd0, cfg.pole_pairs};
      mbm_pkg::CFG_TIMEOUT: prdata = {16'd0, cfg.reply_timeout_ms};
      mbm_pkg::CFG_GAP:     prdata = {16'd0, cfg.frame_gap_ms};
      default:              prdata = 32'd0;
    endcase
  end

  mbm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd)
  );

  mbm_dp #(.REPLY_BYTES(REPLY_BYTES)) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .kind_in (kind),
    .rx_in   (rx_byte),
    .now_in  (now_ms),
    .dir_in  (motor_dir),
    .rpm_in  (rpm_setpoint),
    .cmd     (cmd),
    .sts     (sts),
    .res     (res)
  );

  assign out_free = !out_valid || !out_stall;

  // output register: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_stat || cmd.emit_tx) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_stat || cmd.emit_tx) begin
      is_tx          <= res.is_tx;
      tx_byte        <= res.tx_byte;
      last           <= res.last;
      motor_on       <= res.motor_on;
      reply_class    <= res.reply_class;
      measured_rpm   <= res.measured_rpm;
      fault_code     <= res.fault_code;
      exception_code <= res.exception_code;
      link_up        <= res.link_up;
      awaiting_reply <= res.awaiting_reply;
    end
  end

endmodule
`default_nettype wire
